// ===== hdl/ucmc_pkg.sv =====
// Shared types, constants and mapping functions for the case map classifier.
`timescale 1ns / 1ps

package ucmc_pkg;

    localparam int unsigned CP_W = 21;

    typedef logic [CP_W-1:0] t_code;

    // Offsets between the case members of a block
    localparam t_code OFS_BLOCK = t_code'(32'h20);
    localparam t_code OFS_CYR   = t_code'(32'h50);
    localparam t_code OFS_PAIR  = t_code'(32'h1);

    typedef struct packed {
        t_code lower_code;
        t_code upper_code;
        logic  is_upper;
        logic  is_lower;
        logic  is_digit;
        logic  is_whitespace;
    } t_map_result;

    function automatic logic in_range(input t_code c, input t_code lo, input t_code hi);
        return (c >= lo) && (c <= hi);
    endfunction

    function automatic t_code map_lower(input t_code c);
        logic odd;
        odd = c[0];
        if (in_range(c, t_code'(32'h41), t_code'(32'h5A)))              return c + OFS_BLOCK;
        else if (in_range(c, t_code'(32'hC0), t_code'(32'hD6)))         return c + OFS_BLOCK;
        else if (in_range(c, t_code'(32'hD8), t_code'(32'hDE)))         return c + OFS_BLOCK;
        else if (in_range(c, t_code'(32'h100), t_code'(32'h136)) && !odd) return c + OFS_PAIR;
        else if (in_range(c, t_code'(32'h139), t_code'(32'h147)) && odd)  return c + OFS_PAIR;
        else if (in_range(c, t_code'(32'h14A), t_code'(32'h176)) && !odd) return c + OFS_PAIR;
        else if (in_range(c, t_code'(32'h179), t_code'(32'h17D)) && odd)  return c + OFS_PAIR;
        else if (in_range(c, t_code'(32'h400), t_code'(32'h40F)))       return c + OFS_CYR;
        else if (in_range(c, t_code'(32'h410), t_code'(32'h42F)))       return c + OFS_BLOCK;
        else if (in_range(c, t_code'(32'h460), t_code'(32'h480)) && !odd) return c + OFS_PAIR;
        else if (in_range(c, t_code'(32'h48A), t_code'(32'h522)) && !odd) return c + OFS_PAIR;
        else                                                            return c;
    endfunction

    function automatic t_code map_upper(input t_code c);
        logic odd;
        odd = c[0];
        if (in_range(c, t_code'(32'h61), t_code'(32'h7A)))              return c - OFS_BLOCK;
        else if (in_range(c, t_code'(32'hE0), t_code'(32'hF6)))         return c - OFS_BLOCK;
        else if (in_range(c, t_code'(32'hF8), t_code'(32'hFE)))         return c - OFS_BLOCK;
        else if (in_range(c, t_code'(32'h101), t_code'(32'h137)) && odd)  return c - OFS_PAIR;
        else if (in_range(c, t_code'(32'h13A), t_code'(32'h148)) && !odd) return c - OFS_PAIR;
        else if (in_range(c, t_code'(32'h14B), t_code'(32'h177)) && odd)  return c - OFS_PAIR;
        else if (in_range(c, t_code'(32'h17A), t_code'(32'h17E)) && !odd) return c - OFS_PAIR;
        else if (in_range(c, t_code'(32'h450), t_code'(32'h45F)))       return c - OFS_CYR;
        else if (in_range(c, t_code'(32'h430), t_code'(32'h44F)))       return c - OFS_BLOCK;
        else if (in_range(c, t_code'(32'h461), t_code'(32'h481)) && odd)  return c - OFS_PAIR;
        else if (in_range(c, t_code'(32'h48B), t_code'(32'h523)) && odd)  return c - OFS_PAIR;
        else                                                            return c;
    endfunction

    function automatic logic is_white(input t_code c);
        return in_range(c, t_code'(32'h09), t_code'(32'h0D))
            || (c == t_code'(32'h20))   || (c == t_code'(32'h85))
            || (c == t_code'(32'hA0))   || (c == t_code'(32'h1680))
            || (c == t_code'(32'h180E))
            || in_range(c, t_code'(32'h2000), t_code'(32'h200A))
            || (c == t_code'(32'h2028)) || (c == t_code'(32'h2029))
            || (c == t_code'(32'h202F)) || (c == t_code'(32'h205F))
            || (c == t_code'(32'h3000));
    endfunction

endpackage

// ===== hdl/ucmc_map.sv =====
// Combinational case mapping and classification of one code point.
`timescale 1ns / 1ps

module ucmc_map (
    input  ucmc_pkg::t_code       i_code,
    output ucmc_pkg::t_map_result o_result
);

    ucmc_pkg::t_code w_lower;
    ucmc_pkg::t_code w_upper;

    assign w_lower = ucmc_pkg::map_lower(i_code);
    assign w_upper = ucmc_pkg::map_upper(i_code);

    always_comb begin
        o_result.lower_code    = w_lower;
        o_result.upper_code    = w_upper;
        o_result.is_upper      = (w_lower != i_code);
        o_result.is_lower      = (w_upper != i_code);
        o_result.is_digit      = ucmc_pkg::in_range(i_code, ucmc_pkg::t_code'(32'h30),
                                                    ucmc_pkg::t_code'(32'h39));
        o_result.is_whitespace = ucmc_pkg::is_white(i_code);
    end

endmodule

// ===== hdl/unicode_case_map_classifier_top.sv =====
// Top level: input register, mapping logic and result register.
//
//  channel | direction | handshake                 | payload
//  input   | in        | i_in_valid / o_in_ready   | i_code_point
//  result  | out       | o_out_valid / i_out_ready | o_lower_code, o_upper_code, o_is_*
//
// One code point per cycle sustained while the result side keeps draining; an item passes
// the input register, then the result register, with the range compares in between.
// Reset clears both stage valid bits; payload registers are not reset.
// A stalled result holds in the result register; the input register keeps taking
// items while it is empty or the result register is empty or being drained.
`timescale 1ns / 1ps

module unicode_case_map_classifier_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [ucmc_pkg::CP_W-1:0]    i_code_point,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [ucmc_pkg::CP_W-1:0]    o_lower_code,
    output logic [ucmc_pkg::CP_W-1:0]    o_upper_code,
    output logic                         o_is_upper,
    output logic                         o_is_lower,
    output logic                         o_is_digit,
    output logic                         o_is_whitespace
);

    logic                  r_in_valid;
    ucmc_pkg::t_code       r_code;
    logic                  r_out_valid;
    ucmc_pkg::t_map_result r_result;

    logic                  n_in_valid;
    logic                  n_out_valid;
    logic                  w_out_load;
    ucmc_pkg::t_map_result w_map;

    ucmc_map u_map (
        .i_code   (r_code),
        .o_result (w_map)
    );

    // Result register takes a new item when empty or being drained
    assign w_out_load = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || w_out_load;

    always_comb begin
        n_in_valid  = o_in_ready ? i_in_valid : r_in_valid;
        n_out_valid = w_out_load ? r_in_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_code <= i_code_point;
        end
        if (w_out_load && r_in_valid) begin
            r_result <= w_map;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_lower_code    = r_result.lower_code;
    assign o_upper_code    = r_result.upper_code;
    assign o_is_upper      = r_result.is_upper;
    assign o_is_lower      = r_result.is_lower;
    assign o_is_digit      = r_result.is_digit;
    assign o_is_whitespace = r_result.is_whitespace;

`ifndef ASSERT_OFF
    // A held item in the input register moves on whenever the result side frees up
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_out_load) |=> o_out_valid)
        else $error("input item not advanced to result register");

    // Result register captures the mapping of the item it took
    a_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_out_load) |=> (o_lower_code == $past(w_map.lower_code)
                                        && o_upper_code == $past(w_map.upper_code)))
        else $error("result register does not hold the mapped item");

    // A digit has no case
    a_digit_caseless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_digit) |-> (!o_is_upper && !o_is_lower && !o_is_whitespace))
        else $error("digit flagged as cased or whitespace");

    // An empty input register never blocks the input channel
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_in_ready)
        else $error("input blocked while input register empty");
`endif

endmodule

// ===== tb/tb_unicode_case_map_classifier_top.sv =====
// Self-checking testbench for the Unicode case map classifier top level.
`timescale 1ns / 1ps

module tb_unicode_case_map_classifier_top;

    typedef ucmc_pkg::t_code       t_code;
    typedef ucmc_pkg::t_map_result t_map_result;

    localparam int unsigned N_RANDOM    = 1275;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned HOLD_AT     = 300;
    localparam int unsigned DRAIN_AT    = 700;
    localparam int unsigned FLUSH_WAIT  = 10;
    localparam int unsigned PRINT_LIMIT = 40;

    typedef struct packed {
        logic          known;
        t_code         code;
        t_map_result   want;
    } t_dir_row;

    typedef struct {
        t_code         code;
        t_map_result   want;
    } t_due_map;

    localparam int DIR_ROWS = 25;
    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        '{1'b1, 21'h000000, '{21'h000000, 21'h000000, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{1'b1, 21'h1FFFFF, '{21'h1FFFFF, 21'h1FFFFF, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{1'b1, 21'h10FFFF, '{21'h10FFFF, 21'h10FFFF, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{1'b1, 21'h110000, '{21'h110000, 21'h110000, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{1'b1, 21'h000041, '{21'h000061, 21'h000041, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{1'b0, 21'h00007A, '0},
        '{1'b1, 21'h000030, '{21'h000030, 21'h000030, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{1'b0, 21'h000039, '0},
        '{1'b1, 21'h000020, '{21'h000020, 21'h000020, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{1'b0, 21'h0000D7, '0},
        '{1'b0, 21'h0000FE, '0},
        '{1'b0, 21'h000130, '0},
        '{1'b0, 21'h000138, '0},
        '{1'b0, 21'h000137, '0},
        '{1'b0, 21'h00017D, '0},
        '{1'b0, 21'h00017E, '0},
        '{1'b0, 21'h000400, '0},
        '{1'b0, 21'h00045F, '0},
        '{1'b0, 21'h000481, '0},
        '{1'b0, 21'h0004C0, '0},
        '{1'b0, 21'h000523, '0},
        '{1'b0, 21'h001680, '0},
        '{1'b0, 21'h00180E, '0},
        '{1'b0, 21'h00202F, '0},
        '{1'b0, 21'h003000, '0}
    };

    localparam int unsigned EDGE_PTS [16] = '{
        'h41, 'h5A, 'h61, 'h7A, 'hC0, 'hDE, 'hF8, 'hFE,
        'h100, 'h17F, 'h400, 'h42F, 'h450, 'h460, 'h48A, 'h523
    };

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    t_code          i_code_point;
    logic           o_out_valid;
    logic           i_out_ready;
    t_code          o_lower_code;
    t_code          o_upper_code;
    logic           o_is_upper;
    logic           o_is_lower;
    logic           o_is_digit;
    logic           o_is_whitespace;

    t_due_map       maps_due_q [$];
    int unsigned    mismatch_count = 0;
    int unsigned    quiet_cycles   = 0;
    logic           hold_out;

    unicode_case_map_classifier_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_code_point    (i_code_point),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_lower_code    (o_lower_code),
        .o_upper_code    (o_upper_code),
        .o_is_upper      (o_is_upper),
        .o_is_lower      (o_is_lower),
        .o_is_digit      (o_is_digit),
        .o_is_whitespace (o_is_whitespace)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic logic in_span(input t_code c, input int unsigned lo,
                                     input int unsigned hi);
        return (int'(c) >= lo) && (int'(c) <= hi);
    endfunction

    function automatic t_map_result predict_case_map(input t_code cp);
        t_map_result r;
        logic        ev;
        ev = ~cp[0];
        r.lower_code = cp;
        r.upper_code = cp;

        if (in_span(cp, 'h41, 'h5A) || (in_span(cp, 'hC0, 'hDE) && cp != 21'hD7))
            r.lower_code = cp + 21'h20;
        else if ((in_span(cp, 'h100, 'h136) && ev) || (in_span(cp, 'h139, 'h147) && !ev) ||
                 (in_span(cp, 'h14A, 'h176) && ev) || (in_span(cp, 'h179, 'h17D) && !ev) ||
                 (in_span(cp, 'h460, 'h480) && ev) || (in_span(cp, 'h48A, 'h522) && ev))
            r.lower_code = cp + 21'h1;
        else if (in_span(cp, 'h400, 'h40F))
            r.lower_code = cp + 21'h50;
        else if (in_span(cp, 'h410, 'h42F))
            r.lower_code = cp + 21'h20;

        if (in_span(cp, 'h61, 'h7A) || (in_span(cp, 'hE0, 'hFE) && cp != 21'hF7))
            r.upper_code = cp - 21'h20;
        else if ((in_span(cp, 'h101, 'h137) && !ev) || (in_span(cp, 'h13A, 'h148) && ev) ||
                 (in_span(cp, 'h14B, 'h177) && !ev) || (in_span(cp, 'h17A, 'h17E) && ev) ||
                 (in_span(cp, 'h461, 'h481) && !ev) || (in_span(cp, 'h48B, 'h523) && !ev))
            r.upper_code = cp - 21'h1;
        else if (in_span(cp, 'h450, 'h45F))
            r.upper_code = cp - 21'h50;
        else if (in_span(cp, 'h430, 'h44F))
            r.upper_code = cp - 21'h20;

        r.is_upper      = (r.lower_code != cp);
        r.is_lower      = (r.upper_code != cp);
        r.is_digit      = in_span(cp, 'h30, 'h39);
        r.is_whitespace = in_span(cp, 'h09, 'h0D) || in_span(cp, 'h2000, 'h200A) ||
                          cp == 21'h20 || cp == 21'h85 || cp == 21'hA0 ||
                          cp == 21'h1680 || cp == 21'h180E || cp == 21'h2028 ||
                          cp == 21'h2029 || cp == 21'h202F || cp == 21'h205F ||
                          cp == 21'h3000;
        return r;
    endfunction

    // Bias toward mapped ranges, range edges and whitespace; keep some full-width noise.
    function automatic t_code pick_code();
        t_code cp;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: cp = t_code'($urandom_range(0, 'h5FF));
            4:          cp = t_code'($urandom_range(0, 'h7F));
            5: begin
                case ($urandom_range(0, 6))
                    0:       cp = t_code'('h09 + $urandom_range(0, 5) - 1);
                    1:       cp = $urandom_range(0, 1) ? 21'h85 : 21'hA0;
                    2:       cp = $urandom_range(0, 1) ? 21'h1680 : 21'h180E;
                    3:       cp = t_code'('h2000 + $urandom_range(0, 11));
                    4:       cp = t_code'('h2027 + $urandom_range(0, 3));
                    5:       cp = $urandom_range(0, 1) ? 21'h202F : 21'h205F;
                    default: cp = t_code'('h2FFF + $urandom_range(0, 2));
                endcase
            end
            6:          cp = t_code'($urandom_range('h110000, 'h1FFFFF));
            7:          cp = t_code'($urandom());
            default:    cp = t_code'(EDGE_PTS[$urandom_range(0, 15)] + $urandom_range(0, 2) - 1);
        endcase
        return cp;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)      return 0;
        else if (r < 90) return $urandom_range(1, 3);
        else             return $urandom_range(8, 30);
    endfunction

    task automatic note_mismatch(input string field, input t_code cp,
                                 input t_code got, input t_code want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: %s mismatch for code point %06h: got %06h, expected %06h",
                     $time, field, cp, got, want);
    endtask

    // Hold valid and payload until the transfer, then queue the expected map.
    task automatic offer_code(input t_code cp, input t_map_result want);
        t_due_map d;
        i_in_valid   <= 1'b1;
        i_code_point <= cp;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        d.code = cp;
        d.want = want;
        maps_due_q.push_back(d);
    endtask

    task automatic idle_sender(input int unsigned gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_due_map d;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (maps_due_q.size() == 0) begin
                note_mismatch("unexpected result", '0, o_lower_code, '0);
            end else begin
                d = maps_due_q.pop_front();
                if (o_lower_code !== d.want.lower_code)
                    note_mismatch("lower_code", d.code, o_lower_code, d.want.lower_code);
                if (o_upper_code !== d.want.upper_code)
                    note_mismatch("upper_code", d.code, o_upper_code, d.want.upper_code);
                if (o_is_upper !== d.want.is_upper)
                    note_mismatch("is_upper", d.code, t_code'(o_is_upper),
                                  t_code'(d.want.is_upper));
                if (o_is_lower !== d.want.is_lower)
                    note_mismatch("is_lower", d.code, t_code'(o_is_lower),
                                  t_code'(d.want.is_lower));
                if (o_is_digit !== d.want.is_digit)
                    note_mismatch("is_digit", d.code, t_code'(o_is_digit),
                                  t_code'(d.want.is_digit));
                if (o_is_whitespace !== d.want.is_whitespace)
                    note_mismatch("is_whitespace", d.code, t_code'(o_is_whitespace),
                                  t_code'(d.want.is_whitespace));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: random backpressure, plus one long hold-off on request.
    initial begin : result_sink
        int unsigned r;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_out) begin
                hold_out = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    i_out_ready <= 1'b1;
                    repeat ($urandom_range(1, 4)) @(posedge i_clk);
                end else if (r < 70) begin
                    i_out_ready <= 1'b1;
                    repeat ($urandom_range(30, 80)) @(posedge i_clk);
                end else if (r < 93) begin
                    i_out_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end else begin
                    i_out_ready <= 1'b0;
                    repeat ($urandom_range(10, 25)) @(posedge i_clk);
                end
            end
        end
    end

    initial begin : code_source
        t_map_result want;
        t_code       cp;
        int unsigned burst;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_code_point = '0;
        i_out_ready  = 1'b0;
        hold_out     = 1'b0;
        burst        = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_ROWS; k++) begin
            want = DIR_TAB[k].known ? DIR_TAB[k].want : predict_case_map(DIR_TAB[k].code);
            offer_code(DIR_TAB[k].code, want);
            idle_sender(pick_gap());
        end

        for (int unsigned n = 0; n < N_RANDOM; n++) begin
            if (n == HOLD_AT) begin
                // stall the result side while offering back to back
                hold_out = 1'b1;
                burst    = 150;
            end
            if (n == DRAIN_AT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                wait (maps_due_q.size() == 0);
                @(posedge i_clk);
            end
            cp = pick_code();
            offer_code(cp, predict_case_map(cp));
            if (burst > 0)
                burst--;
            else
                idle_sender(pick_gap());
        end

        i_in_valid <= 1'b0;
        wait (maps_due_q.size() == 0);
        repeat (FLUSH_WAIT) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
